### rtl/pcm_wav_stream_encoder_assert.svh
// Assertion macros used by the checker file
`ifndef PCM_WAV_STREAM_ENCODER_ASSERT_SVH
`define PCM_WAV_STREAM_ENCODER_ASSERT_SVH
// implication checked on every clock edge outside reset
`define PWE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define PWE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### rtl/pwe_pkg.sv
// Package: widths, header constants and sample conversion for the WAV encoder
package pwe_pkg;
	localparam int unsigned SampleW = 32;
	localparam int unsigned HdrLen = 44;
	localparam int unsigned QueueDepth = 4;
	localparam logic [3:0] ChanReset = 4'd1;
	localparam logic [18:0] RateReset = 19'd48000;
	localparam logic [29:0] CountReset = 30'd0;
	localparam logic [1:0] RegChan = 2'd0;
	localparam logic [1:0] RegRate = 2'd1;
	localparam logic [1:0] RegCount = 2'd2;

	// word queued between front and back
	typedef struct packed {
		logic        with_hdr;
		logic [15:0] pcm;
	} item_t;

	// round(clamp(x)*32767) in float32, then round half away from zero
	function automatic logic [15:0] float_to_pcm(input logic [31:0] b);
		logic        s;
		logic [7:0]  e;
		logic [23:0] m;
		logic [39:0] prod;
		logic [47:0] sh;
		logic [24:0] keep;
		logic        g, st;
		logic [24:0] r;
		logic [7:0]  k;
		logic [15:0] mag;
		s = b[31];
		e = b[30:23];
		m = {1'b1, b[22:0]};
		mag = 16'd0;
		prod = '0; sh = '0; keep = '0; g = 1'b0; st = 1'b0; r = '0; k = '0;
		if (e == 8'hFF && b[22:0] != 23'd0) begin
			mag = 16'd0;
		end else if (e >= 8'd127) begin
			mag = 16'd32767;
		end else if (e < 8'd103) begin
			// below 2^-24 the product rounds to under 0.5
			mag = 16'd0;
		end else begin
			prod = 40'(m) * 40'd32767;
			// product value = prod * 2^(e-150); float rounding to 24 bits
			if (prod[38]) begin
				keep = 25'(prod[38:15]);
				g = prod[14];
				st = |prod[13:0];
				k = 8'd15;
			end else begin
				keep = 25'(prod[37:14]);
				g = prod[13];
				st = |prod[12:0];
				k = 8'd14;
			end
			r = keep + 25'(g & (st | keep[0]));
			// value = r * 2^(k + e - 150); integer round half away
			sh = 48'({r, 23'd0} >> (8'd150 - e - k));
			mag = sh[38:23] + 16'(sh[22]);
		end
		return s ? 16'(-mag) : mag;
	endfunction
endpackage

### rtl/pcm_wav_stream_encoder.sv
// Encoder: float samples in, 16-bit PCM WAV byte stream out.
// The s_axis channel takes one sample word (tdata = float32 bits).
// The m_axis channel gives one byte per word; tlast marks the last byte
// caused by a sample. The first sample after reset is preceded by the
// 44-byte RIFF/WAVE header built from the APB registers
// channel count (0x0), frame rate (0x4) and sample count (0x8).
// Conversion happens at the front on acceptance, into a small queue;
// a back serialiser drains one byte per cycle while m_axis_tready is high.
// Each sample gives two bytes, so the byte-wide output port sets the
// sample rate; the first sample also carries the 44-byte header.
// Reset clears the queue and the header flag; registers take defaults.
// A stalled receiver holds the byte; the queue fills, then s_axis_tready falls.
module pcm_wav_stream_encoder #(
	parameter int unsigned QDepth = pwe_pkg::QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] sample_bits
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
	output logic        m_axis_tlast,  // last_of_run
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [3:0]  chan_q;
	logic [18:0] rate_q;
	logic [29:0] count_q;
	logic        qv, qm, qp;
	pwe_pkg::item_t qi;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= pwe_pkg::ChanReset;
			rate_q <= pwe_pkg::RateReset;
			count_q <= pwe_pkg::CountReset;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
			if (paddr[3:2] == pwe_pkg::RegChan) chan_q <= pwdata[3:0];
			if (paddr[3:2] == pwe_pkg::RegRate) rate_q <= pwdata[18:0];
			if (paddr[3:2] == pwe_pkg::RegCount) count_q <= pwdata[29:0];
		end
	end
	always_comb begin
		prdata = 32'd0;
		if (paddr[1:0] == 2'd0) begin
			if (paddr[3:2] == pwe_pkg::RegChan) prdata = {28'd0, chan_q};
			if (paddr[3:2] == pwe_pkg::RegRate) prdata = {13'd0, rate_q};
			if (paddr[3:2] == pwe_pkg::RegCount) prdata = {2'd0, count_q};
		end
	end

	pwe_front #(.Depth(QDepth)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_data(s_axis_tdata), .q_valid(qv), .q_more(qm), .q_pop(qp), .q_item(qi)
	);
	pwe_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(qv), .q_more(qm), .q_pop(qp), .q_item(qi),
		.chan(chan_q), .rate(rate_q), .count(count_q),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_byte(m_axis_tdata), .out_last(m_axis_tlast)
	);
endmodule

### rtl/pwe_front.sv
// Front: accepts samples, converts them and queues them with a header flag
module pwe_front #(
	parameter int unsigned Depth = pwe_pkg::QueueDepth
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [31:0]       in_data,
	output logic              q_valid,
	output logic              q_more,
	input  logic              q_pop,
	output pwe_pkg::item_t    q_item
);
	localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
	pwe_pkg::item_t mem_q [Depth];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic          hdr_done_q;
	logic          push;

	assign in_ready = (cnt_q != (AW+1)'(Depth));
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != '0);
	// a word stays at the head once the current one is popped
	assign q_more = (cnt_q > (AW+1)'(1)) || push;
	assign q_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{with_hdr: !hdr_done_q, pcm: pwe_pkg::float_to_pcm(in_data)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
			hdr_done_q <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
				hdr_done_q <= 1'b1;
			end
			if (q_pop) begin
				rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(q_pop);
		end
	end
endmodule

### rtl/pwe_back.sv
// Back: serialises header and sample bytes onto the output stream
module pwe_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  logic           q_more,
	output logic           q_pop,
	input  pwe_pkg::item_t q_item,
	input  logic [3:0]     chan,
	input  logic [18:0]    rate,
	input  logic [29:0]    count,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_byte,
	output logic           out_last
);
	logic [5:0]  idx_q;
	logic        busy_q;
	logic [31:0] data_b, riff_b, brate, bal;
	logic [7:0]  byte_c;
	logic        fire, last_c;
	logic [31:0] w;
	logic [5:0]  first;

	assign data_b = {count, 1'b0};
	assign riff_b = data_b + 32'd36;
	assign brate  = 32'(rate) * 32'({chan, 1'b0});
	assign bal    = {27'd0, chan, 1'b0};
	assign first  = q_item.with_hdr ? 6'd0 : 6'(pwe_pkg::HdrLen);

	always_comb begin
		w = 32'd0;
		unique case (idx_q[5:2])
			4'd0: w = 32'h46464952;
			4'd1: w = riff_b;
			4'd2: w = 32'h45564157;
			4'd3: w = 32'h20746d66;
			4'd4: w = 32'd16;
			4'd5: w = {12'd0, chan, 16'd1};
			4'd6: w = {13'd0, rate};
			4'd7: w = brate;
			4'd8: w = {16'd16, bal[15:0]};
			4'd9: w = 32'h61746164;
			4'd10: w = data_b;
			4'd11: w = {16'd0, q_item.pcm};
			default: w = 32'd0;
		endcase
		unique case (idx_q[1:0])
			2'd0: byte_c = w[7:0];
			2'd1: byte_c = w[15:8];
			2'd2: byte_c = w[23:16];
			default: byte_c = w[31:24];
		endcase
	end

	assign out_valid = busy_q;
	assign out_byte = byte_c;
	assign last_c = (idx_q == 6'd45);
	assign out_last = last_c;
	assign fire = busy_q && out_ready;
	assign q_pop = fire && last_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			busy_q <= 1'b0;
		end else if (!busy_q || q_pop) begin
			// advance to the next queued word without a gap; only the first carries the header
			if (q_pop ? q_more : q_valid) begin
				busy_q <= 1'b1;
				idx_q <= q_pop ? 6'(pwe_pkg::HdrLen) : first;
			end else begin
				busy_q <= 1'b0;
				idx_q <= '0;
			end
		end else if (fire) begin
			idx_q <= idx_q + 6'd1;
		end
	end
endmodule

### rtl/pwe_checker.sv
// Port-level checker for the WAV encoder, bound to the top level
`include "pcm_wav_stream_encoder_assert.svh"
module pwe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast,
	input logic       pready
);
	`PWE_ASSERT_NXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled byte changed")
	`PWE_ASSERT_IMP(a_pready, clk, arst_n, 1'b1, pready, "pready low")
	`PWE_ASSERT_NXT(a_last_gap, clk, arst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast, !(m_axis_tvalid && m_axis_tlast), "two last bytes in a row")
endmodule

bind pcm_wav_stream_encoder pwe_checker u_pwe_checker (
	.clk(clk), .arst_n(arst_n), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
	.m_axis_tlast(m_axis_tlast), .pready(pready)
);
